/* rtl/cola_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// cola_pkg: shared types and constants of the cursor overlay
// Field widths, register indexes, reset values and the divide-by-255 helper
// used by the overlay pipeline.
// ---------------------------------------------------------------------------
package cola_pkg;

    // Fixed field widths.
    localparam int IDX_W       = 12;
    localparam int ARGB_W      = 32;
    localparam int CH_W        = 8;
    localparam int POS_W       = 13;
    localparam int SIDE_CFG_W  = 7;
    localparam int DEPTH_CFG_W = 6;
    localparam int PROD_W      = 16;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CURSOR_LEFT   = 3'd0,
        CFG_CURSOR_TOP    = 3'd1,
        CFG_CURSOR_WIDTH  = 3'd2,
        CFG_CURSOR_HEIGHT = 3'd3,
        CFG_FRAME_WIDTH   = 3'd4,
        CFG_FRAME_HEIGHT  = 3'd5,
        CFG_PIXEL_DEPTH   = 3'd6
    } t_cfg_idx;

    // Register values after reset.
    localparam logic signed [POS_W-1:0] RST_CURSOR_LEFT   = 13'sd0;
    localparam logic signed [POS_W-1:0] RST_CURSOR_TOP    = 13'sd0;
    localparam logic [SIDE_CFG_W-1:0]   RST_CURSOR_WIDTH  = 7'd64;
    localparam logic [SIDE_CFG_W-1:0]   RST_CURSOR_HEIGHT = 7'd64;
    localparam logic [POS_W-1:0]        RST_FRAME_WIDTH   = 13'd1920;
    localparam logic [POS_W-1:0]        RST_FRAME_HEIGHT  = 13'd1080;
    localparam logic [DEPTH_CFG_W-1:0]  RST_PIXEL_DEPTH   = 6'd32;

    // Item kinds carried on tuser.
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_PIXEL = 1'b1;

    // Pixel depths at which the cursor is blended.
    localparam logic [DEPTH_CFG_W-1:0] DEPTH_24 = 6'd24;
    localparam logic [DEPTH_CFG_W-1:0] DEPTH_32 = 6'd32;

    // Alpha end points and rounding offset.
    localparam logic [CH_W-1:0]   ALPHA_OPAQUE = 8'd255;
    localparam logic [CH_W-1:0]   ALPHA_CLEAR  = 8'd0;
    localparam logic [PROD_W-1:0] ROUND_HALF   = 16'd127;

    // Control flags of an item leaving the locate stage.
    typedef struct packed {
        logic valid;
        logic pix;
        logic hit;
        logic wr_ok;
    } t_stage_ctl;

    // Floor of x / 255 for x below 65280, by the reciprocal form
    // (x + (x >> 8) + 1) >> 8.
    function automatic logic [CH_W-1:0] div255(input logic [PROD_W-1:0] x);
        logic [PROD_W:0] s;
        s = {1'b0, x} + {9'd0, x[PROD_W-1:CH_W]} + 17'd1;
        return s[PROD_W-1:CH_W];
    endfunction

endpackage
`default_nettype wire

/* rtl/cursor_overlay_alpha_blend.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// cursor_overlay_alpha_blend: hardware cursor overlay with premultiplied alpha
// Holds a cursor image and blends it over a raster stream of frame pixels.
// ---------------------------------------------------------------------------
// The block takes one item per clock unless the output stalls or the memory
// clear runs; cursor load transactions write one word of the cursor memory
// and give no result. Throughput is bounded by the single cursor memory
// access that every item makes as it leaves the first stage, and the address
// multiply, the channel multiplies and the divide by 255 each sit in a stage
// of their own. After reset the cursor memory is swept to zero, one word a
// cycle over all CURSOR_MAX_SIDE * CURSOR_MAX_SIDE words (4096 at the default
// size), and s_axis_tready stays low until the sweep is done.
// Configuration registers may be written at any time the stream is idle.
// ---------------------------------------------------------------------------
module cursor_overlay_alpha_blend #(
    parameter int CURSOR_MAX_SIDE = 64,
    parameter int COORD_BITS      = 12
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // Item stream in.
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    // cursor_index, cursor_argb, column, row, in_c0, in_c1, in_c2, zero pad
    input  wire logic [((68 + 2*COORD_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // func
    input  wire logic [0:0]                            s_axis_tuser,
    // Result stream out.
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    // out_column, out_row, out_c0, out_c1, out_c2, zero pad
    output logic [((24 + 2*COORD_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
    // covered
    output logic [0:0]                                 m_axis_tuser,
    // Configuration write port.
    input  wire logic                                  i_cfg_we,
    input  wire logic [cola_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [cola_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    import cola_pkg::*;

    localparam int M_W    = ((24 + 2*COORD_BITS + 7) / 8) * 8;
    localparam int DEPTH  = CURSOR_MAX_SIDE * CURSOR_MAX_SIDE;
    localparam int ADDR_W = $clog2(DEPTH);

    // Input field offsets in s_axis_tdata.
    localparam int OFS_ARGB = IDX_W;
    localparam int OFS_COL  = OFS_ARGB + ARGB_W;
    localparam int OFS_ROW  = OFS_COL + COORD_BITS;
    localparam int OFS_C0   = OFS_ROW + COORD_BITS;
    localparam int OFS_C1   = OFS_C0 + CH_W;
    localparam int OFS_C2   = OFS_C1 + CH_W;

    logic signed [POS_W-1:0]  r_cursor_left;
    logic signed [POS_W-1:0]  r_cursor_top;
    logic [SIDE_CFG_W-1:0]    r_cursor_width;
    logic [SIDE_CFG_W-1:0]    r_cursor_height;
    logic [POS_W-1:0]         r_frame_width;
    logic [POS_W-1:0]         r_frame_height;
    logic [DEPTH_CFG_W-1:0]   r_pixel_depth;

    logic                     r_clr_busy;
    logic [ADDR_W-1:0]        r_clr_addr;

    logic                     w_adv;
    logic                     w_accept;
    t_stage_ctl               w_a_ctl;
    logic [ADDR_W-1:0]        w_wr_addr;
    logic [ADDR_W-1:0]        w_rd_addr;
    logic [ARGB_W-1:0]        w_a_argb;
    logic [COORD_BITS-1:0]    w_a_column;
    logic [COORD_BITS-1:0]    w_a_row;
    logic [CH_W-1:0]          w_a_c0;
    logic [CH_W-1:0]          w_a_c1;
    logic [CH_W-1:0]          w_a_c2;
    logic                     w_load_we;
    logic                     w_ram_we;
    logic [ADDR_W-1:0]        w_ram_waddr;
    logic [ARGB_W-1:0]        w_ram_wdata;
    logic [ARGB_W-1:0]        w_ram_rdata;
    logic                     w_out_valid;
    logic                     w_out_covered;
    logic [COORD_BITS-1:0]    w_out_column;
    logic [COORD_BITS-1:0]    w_out_row;
    logic [CH_W-1:0]          w_out_c0;
    logic [CH_W-1:0]          w_out_c1;
    logic [CH_W-1:0]          w_out_c2;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor_left   <= RST_CURSOR_LEFT;
            r_cursor_top    <= RST_CURSOR_TOP;
            r_cursor_width  <= RST_CURSOR_WIDTH;
            r_cursor_height <= RST_CURSOR_HEIGHT;
            r_frame_width   <= RST_FRAME_WIDTH;
            r_frame_height  <= RST_FRAME_HEIGHT;
            r_pixel_depth   <= RST_PIXEL_DEPTH;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_CURSOR_LEFT:   r_cursor_left   <= $signed(i_cfg_data);
                CFG_CURSOR_TOP:    r_cursor_top    <= $signed(i_cfg_data);
                CFG_CURSOR_WIDTH:  r_cursor_width  <= i_cfg_data[SIDE_CFG_W-1:0];
                CFG_CURSOR_HEIGHT: r_cursor_height <= i_cfg_data[SIDE_CFG_W-1:0];
                CFG_FRAME_WIDTH:   r_frame_width   <= i_cfg_data;
                CFG_FRAME_HEIGHT:  r_frame_height  <= i_cfg_data;
                CFG_PIXEL_DEPTH:   r_pixel_depth   <= i_cfg_data[DEPTH_CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Clearing sweep of the cursor memory after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // The whole pipeline moves whenever the output register can move.
    assign w_adv         = !w_out_valid || m_axis_tready;
    assign s_axis_tready = w_adv && !r_clr_busy;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    cola_locate #(
        .CURSOR_MAX_SIDE (CURSOR_MAX_SIDE),
        .COORD_BITS      (COORD_BITS)
    ) u_locate (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_adv           (w_adv),
        .i_accept        (w_accept),
        .i_func          (s_axis_tuser[0]),
        .i_cursor_index  (s_axis_tdata[IDX_W-1:0]),
        .i_cursor_argb   (s_axis_tdata[OFS_ARGB +: ARGB_W]),
        .i_column        (s_axis_tdata[OFS_COL +: COORD_BITS]),
        .i_row           (s_axis_tdata[OFS_ROW +: COORD_BITS]),
        .i_c0            (s_axis_tdata[OFS_C0 +: CH_W]),
        .i_c1            (s_axis_tdata[OFS_C1 +: CH_W]),
        .i_c2            (s_axis_tdata[OFS_C2 +: CH_W]),
        .i_cursor_left   (r_cursor_left),
        .i_cursor_top    (r_cursor_top),
        .i_cursor_width  (r_cursor_width),
        .i_cursor_height (r_cursor_height),
        .i_frame_width   (r_frame_width),
        .i_frame_height  (r_frame_height),
        .i_pixel_depth   (r_pixel_depth),
        .o_ctl           (w_a_ctl),
        .o_wr_addr       (w_wr_addr),
        .o_rd_addr       (w_rd_addr),
        .o_argb          (w_a_argb),
        .o_column        (w_a_column),
        .o_row           (w_a_row),
        .o_c0            (w_a_c0),
        .o_c1            (w_a_c1),
        .o_c2            (w_a_c2)
    );

    // Memory port: loads write and pixels read at the same pipeline point,
    // so every pixel sees all loads accepted before it.
    assign w_load_we   = w_adv && w_a_ctl.valid && !w_a_ctl.pix && w_a_ctl.wr_ok;
    assign w_ram_we    = r_clr_busy || w_load_we;
    assign w_ram_waddr = r_clr_busy ? r_clr_addr : w_wr_addr;
    assign w_ram_wdata = r_clr_busy ? '0 : w_a_argb;

    cola_ram #(
        .WIDTH (ARGB_W),
        .DEPTH (DEPTH)
    ) u_cursor_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_adv),
        .i_raddr (w_rd_addr),
        .o_rdata (w_ram_rdata)
    );

    cola_blend #(
        .COORD_BITS (COORD_BITS)
    ) u_blend (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (w_adv),
        .i_a_ctl    (w_a_ctl),
        .i_a_column (w_a_column),
        .i_a_row    (w_a_row),
        .i_a_c0     (w_a_c0),
        .i_a_c1     (w_a_c1),
        .i_a_c2     (w_a_c2),
        .i_rdata    (w_ram_rdata),
        .o_valid    (w_out_valid),
        .o_column   (w_out_column),
        .o_row      (w_out_row),
        .o_c0       (w_out_c0),
        .o_c1       (w_out_c1),
        .o_c2       (w_out_c2),
        .o_covered  (w_out_covered)
    );

    // Result transaction.
    assign m_axis_tvalid   = w_out_valid;
    assign m_axis_tdata    = M_W'({w_out_c2, w_out_c1, w_out_c0, w_out_row, w_out_column});
    assign m_axis_tuser[0] = w_out_covered;

    // No item enters while the cursor memory is being cleared.
    a_clear_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !s_axis_tready)
        else $error("input ready during cursor memory clear");

    // The clearing sweep owns the write port alone.
    a_clear_owns_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !(w_adv && w_a_ctl.valid))
        else $error("item in flight during cursor memory clear");

    // The sweep ends exactly after the last memory word.
    a_clear_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_clr_busy) |-> ($past(r_clr_addr) == ADDR_W'(DEPTH - 1)))
        else $error("cursor memory clear ended early");

endmodule
`default_nettype wire

/* rtl/cola_ram.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// cola_ram: generic simple dual-port RAM
// One write port and one read port with registered read data; the read
// register holds while the read enable is low.
// ---------------------------------------------------------------------------
module cola_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

/* rtl/cola_locate.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// cola_locate: input stage and cursor address generation
// Registers each accepted item together with its position relative to the
// cursor rectangle, then forms the cursor memory address for pixels and the
// write address for cursor loads.
// ---------------------------------------------------------------------------
module cola_locate #(
    parameter int CURSOR_MAX_SIDE = 64,
    parameter int COORD_BITS      = 12
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_adv,
    input  wire logic                                  i_accept,
    input  wire logic                                  i_func,
    input  wire logic [cola_pkg::IDX_W-1:0]            i_cursor_index,
    input  wire logic [cola_pkg::ARGB_W-1:0]           i_cursor_argb,
    input  wire logic [COORD_BITS-1:0]                 i_column,
    input  wire logic [COORD_BITS-1:0]                 i_row,
    input  wire logic [cola_pkg::CH_W-1:0]             i_c0,
    input  wire logic [cola_pkg::CH_W-1:0]             i_c1,
    input  wire logic [cola_pkg::CH_W-1:0]             i_c2,
    input  wire logic signed [cola_pkg::POS_W-1:0]     i_cursor_left,
    input  wire logic signed [cola_pkg::POS_W-1:0]     i_cursor_top,
    input  wire logic [cola_pkg::SIDE_CFG_W-1:0]       i_cursor_width,
    input  wire logic [cola_pkg::SIDE_CFG_W-1:0]       i_cursor_height,
    input  wire logic [cola_pkg::POS_W-1:0]            i_frame_width,
    input  wire logic [cola_pkg::POS_W-1:0]            i_frame_height,
    input  wire logic [cola_pkg::DEPTH_CFG_W-1:0]      i_pixel_depth,
    output cola_pkg::t_stage_ctl                       o_ctl,
    output logic [$clog2(CURSOR_MAX_SIDE*CURSOR_MAX_SIDE)-1:0] o_wr_addr,
    output logic [$clog2(CURSOR_MAX_SIDE*CURSOR_MAX_SIDE)-1:0] o_rd_addr,
    output logic [cola_pkg::ARGB_W-1:0]                o_argb,
    output logic [COORD_BITS-1:0]                      o_column,
    output logic [COORD_BITS-1:0]                      o_row,
    output logic [cola_pkg::CH_W-1:0]                  o_c0,
    output logic [cola_pkg::CH_W-1:0]                  o_c1,
    output logic [cola_pkg::CH_W-1:0]                  o_c2
);

    import cola_pkg::*;

    localparam int DEPTH   = CURSOR_MAX_SIDE * CURSOR_MAX_SIDE;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int OFS_W   = $clog2(CURSOR_MAX_SIDE);
    localparam int SIDE_W  = $clog2(CURSOR_MAX_SIDE + 1);
    localparam int CMP_W   = (SIDE_W > SIDE_CFG_W) ? SIDE_W : SIDE_CFG_W;
    localparam int FR_W    = ((COORD_BITS > POS_W) ? COORD_BITS : POS_W) + 1;
    localparam int DIF_W   = FR_W + 1;
    localparam int IDXX_W  = ((IDX_W > ADDR_W) ? IDX_W : ADDR_W) + 1;
    localparam int MUL_W   = OFS_W + SIDE_W;

    // Cursor sides above the store's side are taken at the store's side.
    function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_CFG_W-1:0] s);
        logic [CMP_W-1:0] e;
        e = CMP_W'(s);
        return (e > CMP_W'(CURSOR_MAX_SIDE)) ? SIDE_W'(CURSOR_MAX_SIDE) : SIDE_W'(e);
    endfunction

    logic [SIDE_W-1:0]        w_cw;
    logic [SIDE_W-1:0]        w_ch;
    logic signed [DIF_W-1:0]  w_dx;
    logic signed [DIF_W-1:0]  w_dy;
    logic                     w_in_frame;
    logic                     w_in_cursor;
    logic                     w_depth_ok;
    logic                     w_hit;
    logic [IDXX_W-1:0]        w_idx_ext;
    logic                     w_wr_ok;
    logic [MUL_W-1:0]         w_addr;

    logic                     r_valid;
    logic                     r_pix;
    logic                     r_hit;
    logic                     r_wr_ok;
    logic [ADDR_W-1:0]        r_wr_addr;
    logic [ARGB_W-1:0]        r_argb;
    logic [OFS_W-1:0]         r_dx;
    logic [OFS_W-1:0]         r_dy;
    logic [SIDE_W-1:0]        r_cw;
    logic [COORD_BITS-1:0]    r_column;
    logic [COORD_BITS-1:0]    r_row;
    logic [CH_W-1:0]          r_c0;
    logic [CH_W-1:0]          r_c1;
    logic [CH_W-1:0]          r_c2;

    // Position of the incoming pixel relative to the cursor and the frame.
    assign w_cw = clamp_side(i_cursor_width);
    assign w_ch = clamp_side(i_cursor_height);
    assign w_dx = $signed({1'b0, FR_W'(i_column)}) - DIF_W'(i_cursor_left);
    assign w_dy = $signed({1'b0, FR_W'(i_row)}) - DIF_W'(i_cursor_top);

    assign w_in_frame  = (FR_W'(i_column) < FR_W'(i_frame_width)) &&
                         (FR_W'(i_row) < FR_W'(i_frame_height));
    assign w_in_cursor = !w_dx[DIF_W-1] && !w_dy[DIF_W-1] &&
                         ($unsigned(w_dx) < DIF_W'(w_cw)) &&
                         ($unsigned(w_dy) < DIF_W'(w_ch));
    assign w_depth_ok  = (i_pixel_depth == DEPTH_24) || (i_pixel_depth == DEPTH_32);
    assign w_hit       = w_in_frame && w_in_cursor && w_depth_ok;

    // Loads beyond the store are dropped.
    assign w_idx_ext = IDXX_W'(i_cursor_index);
    assign w_wr_ok   = (w_idx_ext < IDXX_W'(DEPTH));

    // Stage valid bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_accept;
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_pix     <= (i_func == FUNC_PIXEL);
            r_hit     <= w_hit;
            r_wr_ok   <= w_wr_ok;
            r_wr_addr <= w_idx_ext[ADDR_W-1:0];
            r_argb    <= i_cursor_argb;
            r_dx      <= w_dx[OFS_W-1:0];
            r_dy      <= w_dy[OFS_W-1:0];
            r_cw      <= w_cw;
            r_column  <= i_column;
            r_row     <= i_row;
            r_c0      <= i_c0;
            r_c1      <= i_c1;
            r_c2      <= i_c2;
        end
    end

    // Cursor memory address of the pixel: row offset times width plus column.
    assign w_addr = MUL_W'(r_dy) * MUL_W'(r_cw) + MUL_W'(r_dx);

    assign o_ctl     = '{valid: r_valid, pix: r_pix, hit: r_hit, wr_ok: r_wr_ok};
    assign o_wr_addr = r_wr_addr;
    assign o_rd_addr = w_addr[ADDR_W-1:0];
    assign o_argb    = r_argb;
    assign o_column  = r_column;
    assign o_row     = r_row;
    assign o_c0      = r_c0;
    assign o_c1      = r_c1;
    assign o_c2      = r_c2;

endmodule
`default_nettype wire

/* rtl/cola_blend.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// cola_blend: premultiplied alpha blend pipeline
// Aligns pixels with the cursor word from memory, scales frame channels by
// inverse alpha, divides by 255 with rounding, adds cursor channels; misses
// and alpha 0 pass, alpha 255 takes the cursor. Holds the output register.
// ---------------------------------------------------------------------------
module cola_blend #(
    parameter int COORD_BITS = 12
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_adv,
    input  wire cola_pkg::t_stage_ctl        i_a_ctl,
    input  wire logic [COORD_BITS-1:0]       i_a_column,
    input  wire logic [COORD_BITS-1:0]       i_a_row,
    input  wire logic [cola_pkg::CH_W-1:0]   i_a_c0,
    input  wire logic [cola_pkg::CH_W-1:0]   i_a_c1,
    input  wire logic [cola_pkg::CH_W-1:0]   i_a_c2,
    input  wire logic [cola_pkg::ARGB_W-1:0] i_rdata,
    output logic                             o_valid,
    output logic [COORD_BITS-1:0]            o_column,
    output logic [COORD_BITS-1:0]            o_row,
    output logic [cola_pkg::CH_W-1:0]        o_c0,
    output logic [cola_pkg::CH_W-1:0]        o_c1,
    output logic [cola_pkg::CH_W-1:0]        o_c2,
    output logic                             o_covered
);

    import cola_pkg::*;

    // Final selection of one channel.
    function automatic logic [CH_W-1:0] mix(
        input logic             hit,
        input logic             opaque,
        input logic             clear,
        input logic [CH_W-1:0]  cur,
        input logic [CH_W-1:0]  dst,
        input logic [PROD_W-1:0] prod
    );
        logic [CH_W-1:0] res;
        if (!hit || clear) begin
            res = dst;
        end else if (opaque) begin
            res = cur;
        end else begin
            res = cur + div255(prod);
        end
        return res;
    endfunction

    logic [CH_W-1:0]       w_alpha;
    logic [CH_W-1:0]       w_inv;

    logic                  r_b_valid;
    logic                  r_b_hit;
    logic [COORD_BITS-1:0] r_b_column;
    logic [COORD_BITS-1:0] r_b_row;
    logic [CH_W-1:0]       r_b_dst0;
    logic [CH_W-1:0]       r_b_dst1;
    logic [CH_W-1:0]       r_b_dst2;

    logic                  r_c_valid;
    logic                  r_c_hit;
    logic                  r_c_opaque;
    logic                  r_c_clear;
    logic [COORD_BITS-1:0] r_c_column;
    logic [COORD_BITS-1:0] r_c_row;
    logic [CH_W-1:0]       r_c_cur0;
    logic [CH_W-1:0]       r_c_cur1;
    logic [CH_W-1:0]       r_c_cur2;
    logic [CH_W-1:0]       r_c_dst0;
    logic [CH_W-1:0]       r_c_dst1;
    logic [CH_W-1:0]       r_c_dst2;
    logic [PROD_W-1:0]     r_c_prod0;
    logic [PROD_W-1:0]     r_c_prod1;
    logic [PROD_W-1:0]     r_c_prod2;

    logic                  r_d_valid;
    logic                  r_d_covered;
    logic [COORD_BITS-1:0] r_d_column;
    logic [COORD_BITS-1:0] r_d_row;
    logic [CH_W-1:0]       r_d_c0;
    logic [CH_W-1:0]       r_d_c1;
    logic [CH_W-1:0]       r_d_c2;

    // Valid bits; cursor loads leave the pipeline after the memory write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else if (i_adv) begin
            r_b_valid <= i_a_ctl.valid && i_a_ctl.pix;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid;
        end
    end

    // Memory read stage: the pixel waits beside the cursor word read.
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_b_hit    <= i_a_ctl.hit;
            r_b_column <= i_a_column;
            r_b_row    <= i_a_row;
            r_b_dst0   <= i_a_c0;
            r_b_dst1   <= i_a_c1;
            r_b_dst2   <= i_a_c2;
        end
    end

    // Scale stage: dst * (255 - alpha) + 127 for each channel.
    assign w_alpha = i_rdata[ARGB_W-1:3*CH_W];
    assign w_inv   = ALPHA_OPAQUE - w_alpha;

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_c_hit    <= r_b_hit;
            r_c_opaque <= (w_alpha == ALPHA_OPAQUE);
            r_c_clear  <= (w_alpha == ALPHA_CLEAR);
            r_c_column <= r_b_column;
            r_c_row    <= r_b_row;
            r_c_cur0   <= i_rdata[CH_W-1:0];
            r_c_cur1   <= i_rdata[2*CH_W-1:CH_W];
            r_c_cur2   <= i_rdata[3*CH_W-1:2*CH_W];
            r_c_dst0   <= r_b_dst0;
            r_c_dst1   <= r_b_dst1;
            r_c_dst2   <= r_b_dst2;
            r_c_prod0  <= PROD_W'(r_b_dst0) * PROD_W'(w_inv) + ROUND_HALF;
            r_c_prod1  <= PROD_W'(r_b_dst1) * PROD_W'(w_inv) + ROUND_HALF;
            r_c_prod2  <= PROD_W'(r_b_dst2) * PROD_W'(w_inv) + ROUND_HALF;
        end
    end

    // Output stage: divide by 255, add the cursor and pick the case.
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_d_covered <= r_c_hit;
            r_d_column  <= r_c_column;
            r_d_row     <= r_c_row;
            r_d_c0 <= mix(r_c_hit, r_c_opaque, r_c_clear, r_c_cur0, r_c_dst0, r_c_prod0);
            r_d_c1 <= mix(r_c_hit, r_c_opaque, r_c_clear, r_c_cur1, r_c_dst1, r_c_prod1);
            r_d_c2 <= mix(r_c_hit, r_c_opaque, r_c_clear, r_c_cur2, r_c_dst2, r_c_prod2);
        end
    end

    assign o_valid   = r_d_valid;
    assign o_covered = r_d_covered;
    assign o_column  = r_d_column;
    assign o_row     = r_d_row;
    assign o_c0      = r_d_c0;
    assign o_c1      = r_d_c1;
    assign o_c2      = r_d_c2;

    // A cursor load never turns into a pixel result.
    a_load_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && i_a_ctl.valid && !i_a_ctl.pix) |=> !r_b_valid)
        else $error("cursor load entered the blend stages");

    // An opaque covered pixel takes the cursor's channel 0 and is marked covered.
    a_opaque_takes_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && r_c_valid && r_c_hit && r_c_opaque)
        |=> (o_c0 == $past(r_c_cur0) && o_covered))
        else $error("opaque cursor pixel not copied to the output");

    // A pixel outside the cursor passes channel 1 unchanged, not marked covered.
    a_miss_passes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && r_c_valid && !r_c_hit)
        |=> (o_c1 == $past(r_c_dst1) && !o_covered))
        else $error("uncovered pixel was altered");

endmodule
`default_nettype wire
